FILE: sv/sps_pkg.sv
`timescale 1ns / 1ps
// shared types, codes, constants and phase tables for the stepper phase sequencer
package sps_pkg;

  // command codes
  localparam logic [1:0] CMD_MOVE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // register indexes
  localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
  localparam logic [1:0] REG_SPEED_RPM     = 2'd1;
  localparam logic [1:0] REG_WIRE_MODE     = 2'd2;

  // wiring modes
  localparam logic [1:0] WIRE_TWO  = 2'd0;
  localparam logic [1:0] WIRE_FOUR = 2'd1;
  localparam logic [1:0] WIRE_FIVE = 2'd2;

  localparam int CFG_W      = 16;
  localparam int INTERVAL_W = 26;
  localparam int DIV_NUM_W  = 26;
  localparam int DIV_DEN_W  = 32;

  localparam logic [DIV_NUM_W-1:0]  US_PER_MINUTE  = 26'd60_000_000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 26'd5000;
  localparam logic [CFG_W-1:0]      SPR_RESET      = 16'd200;
  localparam logic [CFG_W-1:0]      RPM_RESET      = 16'd60;
  localparam logic [1:0]            WIRE_RESET     = WIRE_FOUR;

  // x / 10 is (x * PHASE_RECIP) >> PHASE_SHIFT for any 16-bit x
  localparam logic [15:0] PHASE_RECIP = 16'd52429;
  localparam int          PHASE_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CFG_MUL,
    ST_CFG_GO,
    ST_CFG_WAIT,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_DONE
  } seq_state_t;

  function automatic logic [4:0] two_wire_coils(input logic [1:0] ph);
    logic [4:0] c;
    case (ph)
      2'd0:    c = 5'd2;
      2'd1:    c = 5'd3;
      2'd2:    c = 5'd1;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] four_wire_coils(input logic [1:0] ph);
    logic [4:0] c;
    case (ph)
      2'd0:    c = 5'd5;
      2'd1:    c = 5'd6;
      2'd2:    c = 5'd10;
      default: c = 5'd9;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] five_wire_coils(input logic [3:0] ph);
    logic [4:0] c;
    case (ph)
      4'd0:    c = 5'd22;
      4'd1:    c = 5'd18;
      4'd2:    c = 5'd26;
      4'd3:    c = 5'd10;
      4'd4:    c = 5'd11;
      4'd5:    c = 5'd9;
      4'd6:    c = 5'd13;
      4'd7:    c = 5'd5;
      4'd8:    c = 5'd21;
      4'd9:    c = 5'd20;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/sps_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, for the step interval
module sps_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sps_pkg::DIV_NUM_W-1:0]  num,
  input  logic [sps_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [sps_pkg::DIV_NUM_W-1:0]  quot
);
  import sps_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [CNT_W-1:0]     cnt;
  logic                 done_r;
  logic [DIV_NUM_W-1:0] numsh;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  always_comb begin
    trial = {rem_r, numsh[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DIV_NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      numsh <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt != '0) begin
      numsh <= {numsh[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = numsh;

endmodule

FILE: sv/stepper_phase_sequencer_top.sv
`timescale 1ns / 1ps
// stepper motor full-step phase sequencer, top level
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | command, step_count
//  out     | out_valid / out_ready| coils, stepped, busy_res, position, moving_forward
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
//  an accepted item goes to ST_DONE and the output register loads there once free;
//  a five-wire step first passes ST_MOD_GO and ST_MOD_WAIT for position mod 10
//  by a reciprocal multiply; a write of steps_per_rev or speed_rpm holds in_ready
//  low while the divider works out the step interval, one quotient bit per cycle
//  reset needs no clearing pass; a new word is taken while the output
//  register still holds an untaken result, the next result waits behind it
module stepper_phase_sequencer_top #(
  parameter int ELAPSED_WIDTH  = 32,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic signed [15:0]         step_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [4:0]                 coils,
  output logic                       stepped,
  output logic                       busy_res,
  output logic [15:0]                position,
  output logic                       moving_forward,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [sps_pkg::CFG_W-1:0]  cfg_data
);
  import sps_pkg::*;

  localparam int EW = ELAPSED_WIDTH;
  localparam int PW = POSITION_WIDTH;

  // configuration
  logic [CFG_W-1:0] spr;
  logic [CFG_W-1:0] rpm;
  logic [1:0]       wire_mode;
  logic             cfg_dirty;

  // motor state
  logic [PW-1:0]         step_pos;
  logic                  fwd;
  logic [15:0]           steps_rem;
  logic [EW-1:0]         elapsed;
  logic [4:0]            coil_lv;
  logic [INTERVAL_W-1:0] interval;
  logic [DIV_DEN_W-1:0]  prod;
  logic                  stepped_r;

  seq_state_t state, state_next;

  // divider hookup
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  // five-wire phase
  logic [31:0] mod_prod;
  logic [2:0]  mod_q;
  logic [3:0]  mod_rem;

  logic in_acc;
  logic out_load;

  // per-item update
  logic [CFG_W-1:0] spr_nz;
  logic [CFG_W-1:0] rpm_nz;
  logic [16:0]      lim17;
  logic [16:0]      rev17;
  logic [PW:0]      rev_eff;
  logic [15:0]      rem_ld;
  logic             dir_ld;
  logic [EW-1:0]    el_ld;
  logic             do_step;
  logic [PW:0]      pos_inc;
  logic [PW:0]      rev_m1;
  logic [PW-1:0]    pos_new;
  logic [4:0]       coil_new;
  logic             need_mod;

  sps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ready = (state == ST_IDLE) && !cfg_dirty;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    spr_nz  = (spr == '0) ? CFG_W'(1) : spr;
    rpm_nz  = (rpm == '0) ? CFG_W'(1) : rpm;
    lim17   = 17'(1) << PW;
    rev17   = ({1'b0, spr_nz} > lim17) ? lim17 : {1'b0, spr_nz};
    rev_eff = rev17[PW:0];
    rev_m1  = rev_eff - (PW+1)'(1);

    rem_ld = steps_rem;
    dir_ld = fwd;
    el_ld  = elapsed;
    case (command)
      CMD_MOVE: begin
        if (step_count[15]) begin
          dir_ld = 1'b0;
          rem_ld = 16'(-step_count);
        end else begin
          if (step_count != 16'sd0) begin
            dir_ld = 1'b1;
          end
          rem_ld = step_count;
        end
      end
      CMD_TICK: begin
        if (elapsed != '1) begin
          el_ld = elapsed + EW'(1);
        end
      end
      CMD_STOP: begin
        rem_ld = '0;
      end
      default: begin
      end
    endcase

    do_step = ((command == CMD_MOVE) || (command == CMD_TICK)) && (rem_ld != '0)
              && (el_ld >= EW'(interval));

    // wrap within the revolution, out-of-range positions snap to an end
    pos_inc = {1'b0, step_pos} + (PW+1)'(1);
    if (dir_ld) begin
      pos_new = (pos_inc >= rev_eff) ? '0 : pos_inc[PW-1:0];
    end else if ((step_pos == '0) || ({1'b0, step_pos} >= rev_eff)) begin
      pos_new = rev_m1[PW-1:0];
    end else begin
      pos_new = step_pos - PW'(1);
    end

    coil_new = coil_lv;
    need_mod = 1'b0;
    case (wire_mode)
      WIRE_TWO:  coil_new = two_wire_coils(pos_new[1:0]);
      WIRE_FOUR: coil_new = four_wire_coils(pos_new[1:0]);
      WIRE_FIVE: need_mod = 1'b1;
      default:   coil_new = coil_lv;
    endcase
  end

  // divider works out the interval as 60e6 / (spr * rpm)
  assign div_start = (state == ST_CFG_GO);
  assign div_num   = US_PER_MINUTE;
  assign div_den   = prod;

  // position mod 10: only the low quotient bits matter, the remainder fits in 4 bits
  assign mod_prod = 32'(16'(step_pos)) * 32'(PHASE_RECIP);
  assign mod_rem  = step_pos[3:0] - {mod_q[0], 3'b000} - {mod_q, 1'b0};

  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cfg_dirty) begin
          state_next = ST_CFG_MUL;
        end else if (in_valid) begin
          state_next = (do_step && need_mod) ? ST_MOD_GO : ST_DONE;
        end
      end
      ST_CFG_MUL:  state_next = ST_CFG_GO;
      ST_CFG_GO:   state_next = ST_CFG_WAIT;
      ST_CFG_WAIT: if (div_done) state_next = ST_IDLE;
      ST_MOD_GO:   state_next = ST_MOD_WAIT;
      ST_MOD_WAIT: state_next = ST_DONE;
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spr       <= SPR_RESET;
      rpm       <= RPM_RESET;
      wire_mode <= WIRE_RESET;
      cfg_dirty <= 1'b0;
    end else begin
      if ((state == ST_IDLE) && cfg_dirty) begin
        cfg_dirty <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEPS_PER_REV: begin
            spr       <= cfg_data;
            cfg_dirty <= 1'b1;
          end
          REG_SPEED_RPM: begin
            rpm       <= cfg_data;
            cfg_dirty <= 1'b1;
          end
          REG_WIRE_MODE: wire_mode <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CFG_MUL) begin
      prod <= DIV_DEN_W'(spr_nz) * DIV_DEN_W'(rpm_nz);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOD_GO) begin
      mod_q <= mod_prod[PHASE_SHIFT+2:PHASE_SHIFT];
    end
  end

  // motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_pos  <= '0;
      fwd       <= 1'b0;
      steps_rem <= '0;
      elapsed   <= '0;
      coil_lv   <= '0;
      interval  <= INTERVAL_RESET;
      stepped_r <= 1'b0;
    end else begin
      if (in_acc) begin
        fwd       <= dir_ld;
        stepped_r <= do_step;
        if (do_step) begin
          step_pos  <= pos_new;
          steps_rem <= rem_ld - 16'd1;
          elapsed   <= '0;
          coil_lv   <= coil_new;
        end else begin
          steps_rem <= rem_ld;
          elapsed   <= el_ld;
          if (command == CMD_STOP) begin
            coil_lv <= '0;
          end
        end
      end
      if ((state == ST_CFG_WAIT) && div_done) begin
        interval <= div_quot[INTERVAL_W-1:0];
      end
      if (state == ST_MOD_WAIT) begin
        coil_lv <= five_wire_coils(mod_rem);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coils          <= coil_lv;
      stepped        <= stepped_r;
      busy_res       <= steps_rem != '0;
      position       <= 16'(step_pos);
      moving_forward <= fwd;
    end
  end

`ifndef SYNTH
  // an interval register write blocks new words until the divider has rerun
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we && ((cfg_index == REG_STEPS_PER_REV) || (cfg_index == REG_SPEED_RPM))
    |=> !in_ready)
    else $error("word accepted before interval recompute");

  // a step clears the elapsed counter
  a_step_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && do_step |=> (elapsed == '0) && stepped_r)
    else $error("step did not clear elapsed time");

  // stop cancels the move and drops every coil
  a_stop: assert property (@(posedge clk) disable iff (rst)
    in_acc && (command == CMD_STOP) |=> (steps_rem == '0) && (coil_lv == '0) && !stepped_r)
    else $error("stop left the motor driven");

  // a word is accepted only in the idle state, never while the divider is in use
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (state == ST_IDLE) && !div_done)
    else $error("word accepted during divider use");
`endif

endmodule

FILE: tb/tb_stepper_phase_sequencer_top.sv
`timescale 1ns / 1ps
// testbench for the stepper phase sequencer: random and directed words checked against a predictor
module tb_stepper_phase_sequencer_top;
  import sps_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] WIRE_NONE  = 2'd3;
  localparam int unsigned USEC_PER_MIN = 60_000_000;
  localparam logic [31:0] ELAPSED_TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] cnt;
  } step_word_t;

  typedef struct packed {
    logic [4:0]  coils;
    logic        stepped;
    logic        busy;
    logic [15:0] pos;
    logic        fwd;
  } motor_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = CMD_MOVE;
  logic signed [15:0] step_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] coils;
  logic stepped;
  logic busy_res;
  logic [15:0] position;
  logic moving_forward;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_STEPS_PER_REV;
  logic [CFG_W-1:0] cfg_data = '0;

  stepper_phase_sequencer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .step_count(step_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .coils(coils), .stepped(stepped), .busy_res(busy_res),
    .position(position), .moving_forward(moving_forward),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // register mirror and motor state of the predictor
  logic [15:0] spr_r, rpm_r;
  logic [1:0]  wire_r;
  logic [15:0] pos_s;
  logic        fwd_s;
  logic [16:0] left_s;
  logic [31:0] elapsed_s;
  logic [4:0]  coil_s;
  logic [25:0] intv_s;

  step_word_t word_q[$];
  motor_out_t coil_q[$];
  int  gap_pct = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  logic in_took = 1'b0;
  int  mismatches = 0;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  function automatic void refresh_interval();
    int unsigned s, v, q;
    s = (spr_r == 0) ? 1 : spr_r;
    v = (rpm_r == 0) ? 1 : rpm_r;
    q = (USEC_PER_MIN / s) / v;
    intv_s = q[25:0];
  endfunction

  function automatic logic [4:0] phase_coils(input logic [1:0] wm, input logic [15:0] p);
    logic [4:0] c;
    c = coil_s;
    if (wm == WIRE_TWO) begin
      case (p % 4)
        0: c = 5'd2;
        1: c = 5'd3;
        2: c = 5'd1;
        default: c = 5'd0;
      endcase
    end else if (wm == WIRE_FOUR) begin
      case (p % 4)
        0: c = 5'd5;
        1: c = 5'd6;
        2: c = 5'd10;
        default: c = 5'd9;
      endcase
    end else if (wm == WIRE_FIVE) begin
      case (p % 10)
        0: c = 5'd22;
        1: c = 5'd18;
        2: c = 5'd26;
        3: c = 5'd10;
        4: c = 5'd11;
        5: c = 5'd9;
        6: c = 5'd13;
        7: c = 5'd5;
        8: c = 5'd21;
        default: c = 5'd20;
      endcase
    end
    return c;
  endfunction

  function automatic void reset_motor();
    spr_r = SPR_RESET;
    rpm_r = RPM_RESET;
    wire_r = WIRE_RESET;
    pos_s = '0;
    fwd_s = 1'b0;
    left_s = '0;
    elapsed_s = '0;
    coil_s = '0;
    refresh_interval();
  endfunction

  function automatic motor_out_t advance_motor(input logic [1:0] cmd, input logic [15:0] cnt);
    motor_out_t r;
    logic [16:0] rev;
    logic did;
    did = 1'b0;
    case (cmd)
      CMD_MOVE: begin
        if (cnt[15]) begin
          fwd_s = 1'b0;
          left_s = 17'h10000 - {1'b0, cnt};
        end else begin
          if (cnt != 0) fwd_s = 1'b1;
          left_s = {1'b0, cnt};
        end
      end
      CMD_TICK: if (elapsed_s != ELAPSED_TOP) elapsed_s = elapsed_s + 1;
      CMD_STOP: begin
        left_s = '0;
        coil_s = '0;
      end
      default: ;
    endcase
    if ((cmd == CMD_MOVE || cmd == CMD_TICK) && left_s != 0 && elapsed_s >= {6'd0, intv_s}) begin
      rev = (spr_r == 0) ? 17'd1 : {1'b0, spr_r};
      if (fwd_s) begin
        if ({1'b0, pos_s} + 17'd1 >= rev) pos_s = '0;
        else pos_s = pos_s + 1;
      end else begin
        // out of range after a revolution change lands on the last step
        if (pos_s == 0 || {1'b0, pos_s} >= rev) pos_s = 16'(rev - 17'd1);
        else pos_s = pos_s - 1;
      end
      coil_s = phase_coils(wire_r, pos_s);
      left_s = left_s - 1;
      elapsed_s = '0;
      did = 1'b1;
    end
    r.coils = coil_s;
    r.stepped = did;
    r.busy = (left_s != 0);
    r.pos = pos_s;
    r.fwd = fwd_s;
    return r;
  endfunction

  function automatic step_word_t mk_word(input logic [1:0] cmd, input logic [15:0] cnt);
    step_word_t w;
    w.cmd = cmd;
    w.cnt = cnt;
    return w;
  endfunction

  function automatic step_word_t random_word();
    step_word_t w;
    int unsigned r;
    r = $urandom_range(99);
    w.cnt = 16'($urandom);
    if (r < 55) begin
      w.cmd = CMD_TICK;
    end else if (r < 82) begin
      w.cmd = CMD_MOVE;
      // short moves keep the position near zero so it wraps both ways
      if ($urandom_range(3) != 0) w.cnt = 16'(int'($urandom_range(48)) - 24);
    end else if (r < 93) begin
      w.cmd = CMD_STOP;
    end else begin
      w.cmd = CMD_UNUSED;
    end
    return w;
  endfunction

  // driver: source words and sink stalls, both changed at the falling edge
  always @(negedge clk) begin : drive
    step_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
      send_gap <= 0;
      recv_gap <= 0;
    end else begin
      if (in_valid && !in_took) begin
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(99) < gap_pct) begin
        send_gap <= $urandom_range(15, 0);
        in_valid <= 1'b0;
      end else begin
        w = word_q.pop_front();
        command <= w.cmd;
        step_count <= w.cnt;
        in_valid <= 1'b1;
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < gap_pct / 3) begin
        recv_gap <= $urandom_range(15, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: results first, they always belong to older words
  always @(posedge clk) begin : watch
    motor_out_t w;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (coil_q.size() == 0) begin
          flag_mismatch("result with nothing pending", 1, 0);
        end else begin
          w = coil_q.pop_front();
          if (coils !== w.coils) flag_mismatch("coils", coils, w.coils);
          if (stepped !== w.stepped) flag_mismatch("stepped", stepped, w.stepped);
          if (busy_res !== w.busy) flag_mismatch("busy_res", busy_res, w.busy);
          if (position !== w.pos) flag_mismatch("position", position, w.pos);
          if (moving_forward !== w.fwd) flag_mismatch("moving_forward", moving_forward, w.fwd);
        end
      end
      if (in_valid && in_ready) coil_q.push_back(advance_motor(command, step_count));
    end
  end

  task automatic drain_motor();
    @(posedge clk);
    while (word_q.size() != 0 || in_valid || coil_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    // let the interval divider finish before touching a register
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEPS_PER_REV: begin
        spr_r = val;
        refresh_interval();
      end
      REG_SPEED_RPM: begin
        rpm_r = val;
        refresh_interval();
      end
      default: wire_r = val[1:0];
    endcase
  endtask

  task automatic set_motor(input logic [15:0] spr, input logic [15:0] rpm, input logic [1:0] wm);
    drain_motor();
    write_reg(REG_STEPS_PER_REV, spr);
    write_reg(REG_SPEED_RPM, rpm);
    write_reg(REG_WIRE_MODE, {14'd0, wm});
    @(posedge clk);
  endtask

  initial begin : limit
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned n, k;
    logic [15:0] a, b;
    logic [1:0] wm;
    reset_motor();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    gap_pct = 20;

    // reset settings, interval far too long to step
    word_q.push_back(mk_word(CMD_MOVE, 16'd3));
    word_q.push_back(mk_word(CMD_TICK, 16'hFFFF));
    word_q.push_back(mk_word(CMD_UNUSED, 16'h8000));
    word_q.push_back(mk_word(CMD_STOP, 16'h7FFF));

    // zero interval: a step on every move or tick word while a move runs
    set_motor(16'd1000, 16'd65535, WIRE_FOUR);
    word_q.push_back(mk_word(CMD_MOVE, 16'd5));
    word_q.push_back(mk_word(CMD_TICK, 16'h0000));
    word_q.push_back(mk_word(CMD_TICK, 16'h5555));
    word_q.push_back(mk_word(CMD_MOVE, 16'd0));
    word_q.push_back(mk_word(CMD_TICK, 16'hAAAA));
    word_q.push_back(mk_word(CMD_MOVE, 16'h8000));
    word_q.push_back(mk_word(CMD_TICK, 16'd0));
    word_q.push_back(mk_word(CMD_STOP, 16'd0));
    word_q.push_back(mk_word(CMD_TICK, 16'd0));
    word_q.push_back(mk_word(CMD_MOVE, 16'd10));
    word_q.push_back(mk_word(CMD_UNUSED, 16'd0));
    word_q.push_back(mk_word(CMD_MOVE, 16'h7FFF));
    word_q.push_back(mk_word(CMD_STOP, 16'hFFFF));

    // back up through zero so the position lands on the top of a full revolution
    set_motor(16'd65535, 16'd65535, WIRE_TWO);
    n = pos_s + 1;
    word_q.push_back(mk_word(CMD_MOVE, 16'(-int'(n))));
    repeat (n - 1) word_q.push_back(mk_word(CMD_TICK, 16'd0));
    word_q.push_back(mk_word(CMD_STOP, 16'd0));

    // shrink the revolution under the position, reverse step
    set_motor(16'd1000, 16'd65535, WIRE_FIVE);
    word_q.push_back(mk_word(CMD_MOVE, 16'hFFFF));

    // out of range again, forward step, coils held in the unused wiring mode
    set_motor(16'd999, 16'd65535, WIRE_NONE);
    word_q.push_back(mk_word(CMD_MOVE, 16'd1));
    word_q.push_back(mk_word(CMD_MOVE, 16'hFFFF));

    // zero registers count as one
    set_motor(16'd0, 16'd0, WIRE_FOUR);
    word_q.push_back(mk_word(CMD_MOVE, 16'd2));
    word_q.push_back(mk_word(CMD_TICK, 16'd0));

    for (int ph = 0; ph < 12; ph++) begin
      k = $urandom_range(9);
      if (k < 3) begin
        a = 16'($urandom_range(1200, 916));
        b = 16'd65535;
      end else if (k < 6) begin
        a = 16'($urandom_range(2000, 916));
        b = 16'($urandom_range(65535, 15000));
      end else if (k < 8) begin
        a = 16'($urandom_range(65535, 1024));
        b = 16'($urandom_range(65535, 15000));
      end else if (k == 8) begin
        a = 16'd65535;
        b = 16'd65535;
      end else begin
        a = 16'($urandom);
        b = 16'($urandom);
      end
      wm = ($urandom_range(7) == 0) ? WIRE_NONE : 2'($urandom_range(2));
      set_motor(a, b, wm);
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      repeat (160) word_q.push_back(random_word());
    end

    // closing stretch at full rate
    set_motor(16'd1000, 16'd65535, WIRE_FOUR);
    gap_pct = 0;
    repeat (60) word_q.push_back(random_word());

    drain_motor();
    repeat (50) @(posedge clk);
    if (coil_q.size() != 0) flag_mismatch("results never delivered", 0, coil_q.size());
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
